### rtl/biae_pkg.sv
// Package for the bounded signed-word table engine: command, status and
// sequencer state codes. No dependencies.
`default_nettype none
package biae_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_READ    = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_RMAT    = 3'd3,
    CMD_RMVAL   = 3'd4,
    CMD_REVERSE = 3'd5,
    CMD_SORT    = 3'd6,
    CMD_SEARCH  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,      // dispatch: first step of each command
    S_RD_WAIT, // read data now registered
    S_SHIFT_R, // shift down: read i+1
    S_SHIFT_W, // shift down: write i
    S_FIND,    // value search compare
    S_REV_RB,  // reverse: second read
    S_REV_W1,  // reverse: write low side
    S_REV_W2,  // reverse: write high side
    S_REV_WAIT_GO, // reverse: read next low-side entry
    S_SORT_RD, // sort: read j-1
    S_SORT_CMP,// sort: compare and move
    S_SORT_NXT,// sort: step down to the next lower entry
    S_SORT_ADV,// sort: move on to the next key
    S_BS,      // binary search: read mid
    S_BS_CMP,  // binary search: compare
    S_BS_CHK,  // binary search: check the lower-bound entry
    S_DONE
  } state_t;

  // Signed order of two words.
  function automatic logic less_than(input logic [31:0] a, input logic [31:0] b);
    less_than = $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

### rtl/biae_mem.sv
// Single-port element store with registered read for the table engine.
// Depends on nothing but its parameters.
`default_nettype none
module biae_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/bounded_int_array_engine.sv
// Top level of the bounded signed-word table engine: sequencer driving one
// store port and signed compare logic. Uses biae_pkg and biae_mem.
//
//  channel | direction | tdata fields (low bit up)
//  in_     | slave     | command[2:0], index[8:3], value[40:9], zero pad to 48
//  out_    | master    | read_value[31:0], found_index[37:32], status[39:38],
//          |           | count[46:40], empty_res[47]
//
// One word is worked at a time; in_tready is high only while the sequencer
// is idle and no result is waiting. Append, write and any rejected command
// pass S_RD and S_DONE; read adds S_RD_WAIT. Remove shifts each entry down
// via S_SHIFT_R and S_SHIFT_W; remove by value first scans in S_FIND, one
// entry compared at a time. Reverse swaps each pair via S_REV_RB, S_REV_W1,
// S_REV_W2 and S_REV_WAIT_GO. Sort is insertion sort (S_SORT_RD, S_SORT_ADV
// per key, S_SORT_CMP, S_SORT_NXT per move); search takes S_BS and S_BS_CMP
// per halving step plus one check read. All share the single memory port.
// Reset (rst_n low, synchronous) clears the count and the sequencer; the
// store itself is not cleared. A result waits in the output register while
// out_tready is low, and the next word is taken once it has been delivered.
`default_nettype none
module bounded_int_array_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // command, index, value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata  // read_value, found_index, status, count, empty_res
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  biae_pkg::state_t state_r, state_nxt;
  biae_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [31:0] val_r, val_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0] t_r, t_nxt;       // held word (swap / insertion key)
  logic [31:0] rd_r, rd_nxt;
  logic [5:0]  fnd_r, fnd_nxt;
  biae_pkg::status_t st_r, st_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  logic [CW-1:0] mid;
  logic [CW-1:0] idx_ext;

  biae_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_tready  = (state_r == biae_pkg::S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {(cnt_r == '0), 7'(cnt_r), st_r, fnd_r, rd_r};
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_ext    = CW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= biae_pkg::S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt; idx_r <= idx_nxt; val_r <= val_nxt;
    i_r <= i_nxt; j_r <= j_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    t_r <= t_nxt; rd_r <= rd_nxt; fnd_r <= fnd_nxt; st_r <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; idx_nxt = idx_r; val_nxt = val_r;
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; lo_nxt = lo_r; hi_nxt = hi_r;
    t_nxt = t_r; rd_nxt = rd_r; fnd_nxt = fnd_r; st_nxt = st_r;
    ov_nxt = ov_r && !out_tready;
    we = 1'b0; addr = '0; wdata = val_r;
    unique case (state_r)
      biae_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt = biae_pkg::cmd_t'(in_tdata[2:0]);
          idx_nxt = in_tdata[8:3];
          val_nxt = in_tdata[40:9];
          rd_nxt = '0; fnd_nxt = '0; st_nxt = biae_pkg::ST_OK;
          i_nxt = '0; lo_nxt = '0; hi_nxt = cnt_r;
          state_nxt = biae_pkg::S_RD;
        end
      end
      biae_pkg::S_RD: begin
        // Dispatch: first step of each command.
        state_nxt = biae_pkg::S_DONE;
        unique case (cmd_r)
          biae_pkg::CMD_APPEND: begin
            if (cnt_r >= CW'(DEPTH)) begin
              st_nxt = biae_pkg::ST_FULL;
            end else begin
              we = 1'b1; addr = AW'(cnt_r); cnt_nxt = cnt_r + 1'b1;
            end
          end
          biae_pkg::CMD_READ: begin
            if (idx_ext >= cnt_r) st_nxt = biae_pkg::ST_RANGE;
            else begin
              addr = AW'(idx_r); state_nxt = biae_pkg::S_RD_WAIT;
            end
          end
          biae_pkg::CMD_WRITE: begin
            if (idx_ext >= cnt_r) st_nxt = biae_pkg::ST_RANGE;
            else begin
              we = 1'b1; addr = AW'(idx_r);
            end
          end
          biae_pkg::CMD_RMAT: begin
            if (idx_ext >= cnt_r) st_nxt = biae_pkg::ST_RANGE;
            else begin
              i_nxt = idx_ext; state_nxt = biae_pkg::S_SHIFT_R;
            end
          end
          biae_pkg::CMD_RMVAL: begin
            if (cnt_r == '0) st_nxt = biae_pkg::ST_MISSING;
            else begin
              addr = '0; state_nxt = biae_pkg::S_FIND;
            end
          end
          biae_pkg::CMD_REVERSE: begin
            if (cnt_r > CW'(1)) begin
              i_nxt = '0; j_nxt = cnt_r - 1'b1;
              addr = '0; state_nxt = biae_pkg::S_REV_RB;
            end
          end
          biae_pkg::CMD_SORT: begin
            if (cnt_r > CW'(1)) begin
              i_nxt = CW'(1); j_nxt = CW'(1);
              addr = AW'(1); state_nxt = biae_pkg::S_SORT_RD;
              t_nxt = '0;
            end
          end
          biae_pkg::CMD_SEARCH: begin
            state_nxt = biae_pkg::S_BS;
          end
          default: ;
        endcase
      end
      biae_pkg::S_RD_WAIT: begin
        rd_nxt = rdata; state_nxt = biae_pkg::S_DONE;
      end
      biae_pkg::S_FIND: begin
        if (rdata == val_r) begin
          state_nxt = biae_pkg::S_SHIFT_R;
        end else if (i_r + 1'b1 >= cnt_r) begin
          st_nxt = biae_pkg::ST_MISSING; state_nxt = biae_pkg::S_DONE;
        end else begin
          i_nxt = i_r + 1'b1; addr = AW'(i_r + 1'b1);
        end
      end
      biae_pkg::S_SHIFT_R: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; state_nxt = biae_pkg::S_DONE;
        end else begin
          addr = AW'(i_r + 1'b1); state_nxt = biae_pkg::S_SHIFT_W;
        end
      end
      biae_pkg::S_SHIFT_W: begin
        we = 1'b1; addr = AW'(i_r); wdata = rdata;
        i_nxt = i_r + 1'b1; state_nxt = biae_pkg::S_SHIFT_R;
      end
      biae_pkg::S_REV_RB: begin
        // rdata holds entry i; fetch entry j.
        t_nxt = rdata; addr = AW'(j_r); state_nxt = biae_pkg::S_REV_W1;
      end
      biae_pkg::S_REV_W1: begin
        we = 1'b1; addr = AW'(i_r); wdata = rdata; state_nxt = biae_pkg::S_REV_W2;
      end
      biae_pkg::S_REV_W2: begin
        we = 1'b1; addr = AW'(j_r); wdata = t_r;
        if (i_r + 1'b1 < j_r - 1'b1) begin
          i_nxt = i_r + 1'b1; j_nxt = j_r - 1'b1;
          state_nxt = biae_pkg::S_REV_WAIT_GO;
        end else begin
          state_nxt = biae_pkg::S_DONE;
        end
      end
      biae_pkg::S_REV_WAIT_GO: begin
        addr = AW'(i_r); state_nxt = biae_pkg::S_REV_RB;
      end
      biae_pkg::S_SORT_RD: begin
        // Key element i is now in rdata; start comparing with j-1.
        t_nxt = rdata; j_nxt = i_r;
        addr = AW'(i_r - 1'b1); state_nxt = biae_pkg::S_SORT_CMP;
      end
      biae_pkg::S_SORT_CMP: begin
        // rdata holds entry j-1.
        if (biae_pkg::less_than(t_r, rdata)) begin
          we = 1'b1; addr = AW'(j_r); wdata = rdata;
          j_nxt = j_r - 1'b1;
          state_nxt = biae_pkg::S_SORT_NXT;
        end else begin
          we = 1'b1; addr = AW'(j_r); wdata = t_r;
          state_nxt = biae_pkg::S_SORT_ADV;
        end
      end
      biae_pkg::S_SORT_NXT: begin
        if (j_r == '0) begin
          we = 1'b1; addr = '0; wdata = t_r; state_nxt = biae_pkg::S_SORT_ADV;
        end else begin
          addr = AW'(j_r - 1'b1); state_nxt = biae_pkg::S_SORT_CMP;
        end
      end
      biae_pkg::S_SORT_ADV: begin
        if (i_r + 1'b1 >= cnt_r) state_nxt = biae_pkg::S_DONE;
        else begin
          i_nxt = i_r + 1'b1; addr = AW'(i_r + 1'b1);
          state_nxt = biae_pkg::S_SORT_RD;
        end
      end
      biae_pkg::S_BS: begin
        if (lo_r < hi_r) begin
          addr = AW'(mid); state_nxt = biae_pkg::S_BS_CMP;
        end else if (lo_r < cnt_r) begin
          addr = AW'(lo_r); state_nxt = biae_pkg::S_BS_CHK;
        end else begin
          st_nxt = biae_pkg::ST_MISSING; state_nxt = biae_pkg::S_DONE;
        end
      end
      biae_pkg::S_BS_CMP: begin
        if (biae_pkg::less_than(rdata, val_r)) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = biae_pkg::S_BS;
      end
      biae_pkg::S_BS_CHK: begin
        if (rdata == val_r) fnd_nxt = 6'(lo_r);
        else st_nxt = biae_pkg::ST_MISSING;
        state_nxt = biae_pkg::S_DONE;
      end
      biae_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; state_nxt = biae_pkg::S_IDLE;
        end
      end
      default: state_nxt = biae_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("count above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(state_r == biae_pkg::S_DONE)) else $error("ready while busy");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> state_r != biae_pkg::S_IDLE || $past(state_r) != biae_pkg::S_IDLE)
    else $error("count moved while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the bounded signed-word table engine. A local
// predictor keeps its own copy of the table; a small scoreboard matches results.
// Depends on biae_pkg and bounded_int_array_engine.
`default_nettype none

class table_scoreboard;
  logic [31:0] words[64];
  int unsigned live;
  logic [47:0] pending[$];
  int errors;

  function new();
    live = 0;
    errors = 0;
  endfunction

  function void remove_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < live; i++) words[i] = words[i + 1];
    live--;
  endfunction

  // Work out the result of one accepted word and queue it.
  function void note_command(logic [47:0] w);
    biae_pkg::cmd_t cmd;
    logic [5:0] idx;
    logic [31:0] val, rd, tmp;
    logic [5:0] found;
    biae_pkg::status_t st;
    int unsigned lo, hi, mid, j;
    cmd = biae_pkg::cmd_t'(w[2:0]);
    idx = w[8:3];
    val = w[40:9];
    rd = '0;
    found = '0;
    st = biae_pkg::ST_OK;
    case (cmd)
      biae_pkg::CMD_APPEND: begin
        if (live >= 64) st = biae_pkg::ST_FULL;
        else begin
          words[live] = val;
          live++;
        end
      end
      biae_pkg::CMD_READ: begin
        if (idx >= live) st = biae_pkg::ST_RANGE;
        else rd = words[idx];
      end
      biae_pkg::CMD_WRITE: begin
        if (idx >= live) st = biae_pkg::ST_RANGE;
        else words[idx] = val;
      end
      biae_pkg::CMD_RMAT: begin
        if (idx >= live) st = biae_pkg::ST_RANGE;
        else remove_entry(idx);
      end
      biae_pkg::CMD_RMVAL: begin
        st = biae_pkg::ST_MISSING;
        for (int unsigned i = 0; i < live; i++) begin
          if (words[i] == val) begin
            remove_entry(i);
            st = biae_pkg::ST_OK;
            break;
          end
        end
      end
      biae_pkg::CMD_REVERSE: begin
        for (int unsigned i = 0; i < live / 2; i++) begin
          tmp = words[i];
          words[i] = words[live - 1 - i];
          words[live - 1 - i] = tmp;
        end
      end
      biae_pkg::CMD_SORT: begin
        for (int unsigned i = 1; i < live; i++) begin
          tmp = words[i];
          j = i;
          while (j > 0 && $signed(words[j - 1]) > $signed(tmp)) begin
            words[j] = words[j - 1];
            j--;
          end
          words[j] = tmp;
        end
      end
      default: begin
        // Lower-bound binary search on the entries as they stand.
        lo = 0;
        hi = live;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if ($signed(words[mid]) < $signed(val)) lo = mid + 1;
          else hi = mid;
        end
        if (lo < live && words[lo] == val) found = lo[5:0];
        else st = biae_pkg::ST_MISSING;
      end
    endcase
    pending.push_back({live == 0, live[6:0], st, found, rd});
  endfunction

  function void check_result(logic [47:0] got);
    logic [47:0] exp;
    if (pending.size() == 0) begin
      $error("result word with no expectation: %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[31:0] !== exp[31:0]) begin
      $error("read_value expected %h actual %h", exp[31:0], got[31:0]);
      errors++;
    end
    if (got[37:32] !== exp[37:32]) begin
      $error("found_index expected %0d actual %0d", exp[37:32], got[37:32]);
      errors++;
    end
    if (got[39:38] !== exp[39:38]) begin
      $error("status expected %0d actual %0d", exp[39:38], got[39:38]);
      errors++;
    end
    if (got[46:40] !== exp[46:40]) begin
      $error("count expected %0d actual %0d", exp[46:40], got[46:40]);
      errors++;
    end
    if (got[47] !== exp[47]) begin
      $error("empty_res expected %0d actual %0d", exp[47], got[47]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;  // command, index, value
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;      // read_value, found_index, status, count, empty_res

  // Long receiver hold-off is requested by the stimulus and run by the sink.
  bit hold_request = 1'b0;
  bit stim_done = 1'b0;

  table_scoreboard board;

  bounded_int_array_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one word after a random gap and wait until it is taken. The
  // scoreboard sees the word at the edge where the handshake completes.
  // Valid drops only when a gap follows; otherwise the next word replaces
  // the data at that same edge.
  task automatic send_word(biae_pkg::cmd_t cmd, logic [5:0] idx, logic [31:0] val,
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, val, idx, cmd};
    do @(posedge clk); while (!in_tready);
    board.note_command({7'd0, val, idx, cmd});
  endtask

  // Random word biased toward the live range and toward repeated values, so
  // that removes and searches hit real entries.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20)) - 10);
      2: return board.live > 0 ? board.words[$urandom_range(0, board.live - 1)] : $urandom();
      default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
    endcase
  endfunction

  task automatic random_word(bit no_gap);
    biae_pkg::cmd_t cmd;
    logic [5:0] idx;
    int r;
    r = $urandom_range(0, 99);
    // Appends dominate while the table is small so it reaches full depth.
    if (r < (board.live < 48 ? 40 : 20)) cmd = biae_pkg::CMD_APPEND;
    else cmd = biae_pkg::cmd_t'($urandom_range(1, 7));
    if ($urandom_range(0, 3) == 0 || board.live == 0) idx = 6'($urandom());
    else idx = 6'($urandom_range(0, board.live - 1));
    send_word(cmd, idx, pick_value(), no_gap);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-table behavior, field extremes, full table.
    send_word(biae_pkg::CMD_READ, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_REVERSE, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_SORT, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_SEARCH, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_RMVAL, 6'd63, 32'hffffffff, 1'b0);
    send_word(biae_pkg::CMD_APPEND, 6'd63, 32'h7fffffff, 1'b0);
    send_word(biae_pkg::CMD_APPEND, 6'd0, 32'h80000000, 1'b0);
    send_word(biae_pkg::CMD_APPEND, 6'd0, 32'hffffffff, 1'b0);
    send_word(biae_pkg::CMD_READ, 6'd2, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_WRITE, 6'd1, 32'h0000_0000, 1'b0);
    send_word(biae_pkg::CMD_WRITE, 6'd63, 32'h1, 1'b0);
    send_word(biae_pkg::CMD_SEARCH, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_REVERSE, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_SORT, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_SEARCH, 6'd0, 32'h7fffffff, 1'b0);
    send_word(biae_pkg::CMD_SEARCH, 6'd0, 32'h5, 1'b0);
    send_word(biae_pkg::CMD_RMAT, 6'd1, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_RMVAL, 6'd0, 32'h7fffffff, 1'b0);
    send_word(biae_pkg::CMD_RMAT, 6'd5, 32'h0, 1'b0);
    // Fill the table to full depth, then one append too many.
    while (board.live < 64) send_word(biae_pkg::CMD_APPEND, 6'd0, $urandom(), 1'b1);
    send_word(biae_pkg::CMD_APPEND, 6'd0, 32'h12345678, 1'b0);
    send_word(biae_pkg::CMD_READ, 6'd63, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_SORT, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_REVERSE, 6'd0, 32'h0, 1'b0);
    send_word(biae_pkg::CMD_RMAT, 6'd63, 32'h0, 1'b0);

    // Sender pauses until every expected result is in.
    wait_drained();

    // Receiver holds off for a long stretch while words keep coming.
    hold_request = 1'b1;
    for (int k = 0; k < 6; k++) random_word(1'b1);
    hold_request = 1'b0;

    for (int k = 0; k < 760; k++) begin
      random_word(k % 200 < 40);
      // Empty the table now and then so the low counts come back around.
      if (k % 300 == 299) begin
        while (board.live > 0) send_word(biae_pkg::CMD_RMAT, 6'd0, 32'h0, 1'b1);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    stim_done = 1'b1;
  end

  // Result side: random stalls per word, with a long hold when asked.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_result(out_tdata);
    end
  end

  initial begin
    wait (stim_done);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS bounded_int_array_engine");
    end else begin
      $display("FAIL bounded_int_array_engine");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL bounded_int_array_engine");
    $finish;
  end
endmodule
`default_nettype wire
